>>> design/lcdni_pkg.sv
package lcdni_pkg;

  // Request codes on the func field.
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_INSTR  = 3'd1;
  localparam logic [2:0] FUNC_CHAR   = 3'd2;
  localparam logic [2:0] FUNC_INIT   = 3'd3;
  localparam logic [2:0] FUNC_CURSOR = 3'd4;
  localparam logic [2:0] FUNC_CLEAR  = 3'd5;
  localparam logic [2:0] FUNC_POWER  = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] CFG_IDX_ENABLE_PULSE = 3'd0;
  localparam logic [2:0] CFG_IDX_SHORT_WAIT   = 3'd1;
  localparam logic [2:0] CFG_IDX_CLEAR_WAIT   = 3'd2;
  localparam logic [2:0] CFG_IDX_POWERUP_WAIT = 3'd3;
  localparam logic [2:0] CFG_IDX_RESET_LONG   = 3'd4;
  localparam logic [2:0] CFG_IDX_RESET_SHORT  = 3'd5;

  // Configuration reset values.
  localparam logic [7:0]  ENABLE_PULSE_RST = 8'd1;
  localparam logic [15:0] SHORT_WAIT_RST   = 16'd80;
  localparam logic [15:0] CLEAR_WAIT_RST   = 16'd4000;
  localparam logic [19:0] POWERUP_WAIT_RST = 20'd100000;
  localparam logic [15:0] RESET_LONG_RST   = 16'd10000;
  localparam logic [15:0] RESET_SHORT_RST  = 16'd200;

  // Display instruction bytes.
  localparam logic [7:0] CMD_FUNC_RESET = 8'h30;
  localparam logic [7:0] CMD_FUNC_SET4  = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_ENTRY      = 8'h06;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [7:0] CMD_SET_CURSOR = 8'h80;

  // Init sequence steps: 1..4 are lone nibbles, 5..9 are full bytes.
  localparam logic [3:0] INIT_STEP_NONE        = 4'd0;
  localparam logic [3:0] INIT_STEP_FIRST       = 4'd1;
  localparam logic [3:0] INIT_STEP_SHORT_A     = 4'd2;
  localparam logic [3:0] INIT_STEP_SHORT_B     = 4'd3;
  localparam logic [3:0] INIT_STEP_LAST_NIBBLE = 4'd4;
  localparam logic [3:0] INIT_STEP_FIRST_BYTE  = 4'd5;
  localparam logic [3:0] INIT_STEP_LAST        = 4'd9;

  // Classified request kinds passed from the front to the back.
  typedef enum logic [2:0] {
    REQ_NONE,
    REQ_BYTE,
    REQ_INIT,
    REQ_POWER,
    REQ_BAD
  } req_kind_e;

  typedef struct packed {
    req_kind_e  kind;
    logic [7:0] data_byte;
    logic       rs;
  } req_t;

  typedef struct packed {
    logic [7:0]  enable_pulse;
    logic [15:0] short_wait;
    logic [15:0] clear_wait;
    logic [19:0] powerup_wait;
    logic [15:0] reset_long;
    logic [15:0] reset_short;
  } cfg_t;

  typedef struct packed {
    logic [3:0] data_pins;
    logic       rs_pin;
    logic       enable_pin;
    logic       power_pin;
    logic       busy_res;
    logic       dropped;
  } res_t;

  // Byte sent for each full-byte init step, counted from the first byte step.
  function automatic logic [7:0] init_byte(logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = CMD_FUNC_SET4;
      3'd1:    b = CMD_DISP_OFF;
      3'd2:    b = CMD_CLEAR;
      3'd3:    b = CMD_ENTRY;
      default: b = CMD_DISP_ON;
    endcase
    return b;
  endfunction

endpackage

>>> design/lcdni_front.sv
module lcdni_front #(
  parameter int COLUMNS = 16
) (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          func_i,
  input  logic [7:0]          data_byte_i,
  input  logic [1:0]          row_i,
  input  logic [5:0]          column_i,
  input  logic                queue_full_i,
  output logic                push_o,
  output lcdni_pkg::req_t     req_o
);

  logic       cursor_ok;
  logic [5:0] col_m1;

  // Accept whenever the queue has room.
  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i & ~queue_full_i;

  // Cursor position check and address bits.
  assign cursor_ok = ((row_i == 2'd1) || (row_i == 2'd2)) && (column_i != 6'd0) &&
                     (column_i <= 6'(COLUMNS));
  assign col_m1    = column_i - 6'd1;

  // Turn the request code into a byte to send or a control action.
  always_comb begin
    req_o.kind      = lcdni_pkg::REQ_NONE;
    req_o.data_byte = data_byte_i;
    req_o.rs        = 1'b0;
    case (func_i)
      lcdni_pkg::FUNC_TICK: begin
        req_o.kind = lcdni_pkg::REQ_NONE;
      end
      lcdni_pkg::FUNC_INSTR: begin
        req_o.kind = lcdni_pkg::REQ_BYTE;
      end
      lcdni_pkg::FUNC_CHAR: begin
        req_o.kind = lcdni_pkg::REQ_BYTE;
        req_o.rs   = 1'b1;
      end
      lcdni_pkg::FUNC_INIT: begin
        req_o.kind = lcdni_pkg::REQ_INIT;
      end
      lcdni_pkg::FUNC_CURSOR: begin
        // Row two starts at address 0x40, so its bit lands above the column.
        req_o.kind      = cursor_ok ? lcdni_pkg::REQ_BYTE : lcdni_pkg::REQ_BAD;
        req_o.data_byte = lcdni_pkg::CMD_SET_CURSOR | {1'b0, row_i == 2'd2, col_m1};
      end
      lcdni_pkg::FUNC_CLEAR: begin
        req_o.kind      = lcdni_pkg::REQ_BYTE;
        req_o.data_byte = lcdni_pkg::CMD_CLEAR;
      end
      lcdni_pkg::FUNC_POWER: begin
        req_o.kind = lcdni_pkg::REQ_POWER;
      end
      default: begin
        req_o.kind = lcdni_pkg::REQ_BAD;
      end
    endcase
  end

endmodule

>>> design/lcdni_queue.sv
module lcdni_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lcdni_pkg::req_t push_req_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output lcdni_pkg::req_t pop_req_o
);

  localparam int Depth = 2;

  lcdni_pkg::req_t                  mem_q [Depth];
  logic [$clog2(Depth)-1:0]         wr_ptr_q, wr_ptr_d;
  logic [$clog2(Depth)-1:0]         rd_ptr_q, rd_ptr_d;
  logic [$clog2(Depth+1)-1:0]       count_q, count_d;

  assign full_o    = (count_q == ($clog2(Depth+1))'(Depth));
  assign valid_o   = (count_q != '0);
  assign pop_req_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

>>> design/lcdni_back.sv
module lcdni_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lcdni_pkg::cfg_t cfg_i,
  input  logic            req_valid_i,
  input  lcdni_pkg::req_t req_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lcdni_pkg::res_t res_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_POWERUP,
    PH_EHIGH,
    PH_ELOW,
    PH_WAIT
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [19:0] wcnt;
    logic [7:0]  pend;
    logic        low_next;
    logic [3:0]  step;
    logic        long_wait;
    logic        rs;
    logic [3:0]  data;
    logic        en;
    logic        power;
  } seq_t;

  seq_t            seq_q, seq_d, seq_n;
  logic            drop;
  logic            out_valid_q;
  lcdni_pkg::res_t res_q;
  logic [19:0]     pulse;

  function automatic logic [19:0] max1_16(logic [15:0] v);
    logic [19:0] r;
    r = (v == 16'd0) ? 20'd1 : {4'd0, v};
    return r;
  endfunction

  function automatic seq_t start_nibble(seq_t s, logic [3:0] nib, logic [19:0] p);
    seq_t r;
    r       = s;
    r.data  = nib;
    r.en    = 1'b1;
    r.phase = PH_EHIGH;
    r.wcnt  = p;
    return r;
  endfunction

  function automatic seq_t start_byte(seq_t s, logic [7:0] b, logic rs, logic [19:0] p);
    seq_t r;
    r           = s;
    r.pend      = b;
    r.low_next  = 1'b1;
    r.rs        = rs;
    r.long_wait = !rs && (b == lcdni_pkg::CMD_CLEAR);
    r           = start_nibble(r, b[7:4], p);
    return r;
  endfunction

  function automatic seq_t start_init_item(seq_t s, logic [19:0] p);
    seq_t       r;
    logic [3:0] nib;
    logic [3:0] idx;
    r   = s;
    idx = s.step - lcdni_pkg::INIT_STEP_FIRST_BYTE;
    if ((s.step >= lcdni_pkg::INIT_STEP_FIRST) &&
        (s.step <= lcdni_pkg::INIT_STEP_LAST_NIBBLE)) begin
      nib = (s.step == lcdni_pkg::INIT_STEP_LAST_NIBBLE) ?
            lcdni_pkg::CMD_FUNC_SET4[7:4] : lcdni_pkg::CMD_FUNC_RESET[7:4];
      r.rs        = 1'b0;
      r.low_next  = 1'b0;
      r.long_wait = 1'b0;
      r           = start_nibble(r, nib, p);
    end else begin
      r = start_byte(r, lcdni_pkg::init_byte(idx[2:0]), 1'b0, p);
    end
    return r;
  endfunction

  function automatic logic [19:0] wait_length(seq_t s, lcdni_pkg::cfg_t c);
    logic [19:0] w;
    if (s.step == lcdni_pkg::INIT_STEP_FIRST) begin
      w = max1_16(c.reset_long);
    end else if ((s.step == lcdni_pkg::INIT_STEP_SHORT_A) ||
                 (s.step == lcdni_pkg::INIT_STEP_SHORT_B)) begin
      w = max1_16(c.reset_short);
    end else begin
      w = max1_16(s.long_wait ? c.clear_wait : c.short_wait);
    end
    return w;
  endfunction

  // One sequencer tick while busy: count down, then move to the next phase.
  function automatic seq_t advance(seq_t s, lcdni_pkg::cfg_t c, logic [19:0] p);
    seq_t r;
    r = s;
    if (r.wcnt != 20'd0) begin
      r.wcnt = r.wcnt - 20'd1;
    end
    if (r.wcnt == 20'd0) begin
      case (r.phase)
        PH_POWERUP: begin
          r = start_init_item(r, p);
        end
        PH_EHIGH: begin
          r.en    = 1'b0;
          r.phase = PH_ELOW;
          r.wcnt  = p;
        end
        PH_ELOW: begin
          if (r.low_next) begin
            r.low_next = 1'b0;
            r          = start_nibble(r, r.pend[3:0], p);
          end else begin
            r.phase = PH_WAIT;
            r.wcnt  = wait_length(r, c);
          end
        end
        default: begin
          if ((r.step >= lcdni_pkg::INIT_STEP_FIRST) &&
              (r.step < lcdni_pkg::INIT_STEP_LAST)) begin
            r.step = r.step + 4'd1;
            r      = start_init_item(r, p);
          end else begin
            r.step  = lcdni_pkg::INIT_STEP_NONE;
            r.phase = PH_IDLE;
          end
        end
      endcase
    end
    return r;
  endfunction

  assign pulse = (cfg_i.enable_pulse == 8'd0) ? 20'd1 : {12'd0, cfg_i.enable_pulse};

  // Take the next tick whenever the output register is free or being emptied.
  assign pop_o = req_valid_i && (!out_valid_q || !out_stall_i);

  // Next sequencer state for the tick at the head of the queue.
  always_comb begin
    seq_n = seq_q;
    drop  = 1'b0;
    if (seq_q.phase != PH_IDLE) begin
      drop  = (req_i.kind != lcdni_pkg::REQ_NONE);
      seq_n = advance(seq_q, cfg_i, pulse);
    end else begin
      case (req_i.kind)
        lcdni_pkg::REQ_NONE: begin
          seq_n = seq_q;
        end
        lcdni_pkg::REQ_BYTE: begin
          seq_n = start_byte(seq_q, req_i.data_byte, req_i.rs, pulse);
        end
        lcdni_pkg::REQ_INIT: begin
          seq_n.step  = lcdni_pkg::INIT_STEP_FIRST;
          seq_n.rs    = 1'b0;
          seq_n.en    = 1'b0;
          seq_n.phase = PH_POWERUP;
          seq_n.wcnt  = (cfg_i.powerup_wait == 20'd0) ? 20'd1 : cfg_i.powerup_wait;
        end
        lcdni_pkg::REQ_POWER: begin
          seq_n.power = req_i.data_byte[0];
        end
        default: begin
          drop = 1'b1;
        end
      endcase
    end
    seq_d = pop_o ? seq_n : seq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= '{phase: PH_IDLE, default: '0};
      out_valid_q <= 1'b0;
    end else begin
      seq_q <= seq_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register: pin state after the tick.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q.data_pins  <= seq_n.data;
      res_q.rs_pin     <= seq_n.rs;
      res_q.enable_pin <= seq_n.en;
      res_q.power_pin  <= seq_n.power;
      res_q.busy_res   <= (seq_n.phase != PH_IDLE);
      res_q.dropped    <= drop;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

>>> design/char_lcd_nibble_interface_unit.sv
// Character LCD controller for a 4-bit bus, one request per timing tick.
// Input channel (in_valid_i / in_stall_o): each item is one tick carrying a
// request code, a byte, and a cursor row and column. A tick with code zero
// just advances timing; other codes start a byte, the init sequence, a
// cursor set, a clear or a power pin change, or are dropped when busy or invalid.
// Output channel (out_valid_o / out_stall_i): one result per tick with the
// LCD pin levels after that tick, the busy flag and the drop flag.
// Configuration: cfg_valid_i with cfg_index_i and cfg_data_i writes one
// timing register; cfg_ready_o is always high. Write only while idle.
// A tick's result passes through the request queue and then the result
// register before it appears on the output channel.
// Throughput: one tick per cycle unless the output stalls; the sequencer
// state updates once per tick, with a two-entry request queue ahead of it.
// When the receiver stalls, the result register holds, the queue fills, and
// in_stall_o rises once both queue entries are taken.
// Reset clears the sequencer to idle with its pins low, the queue empty and
// the timing registers to their defaults; the result register is not reset.
module char_lcd_nibble_interface_unit #(
  parameter int COLUMNS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  data_byte_i,
  input  logic [1:0]  row_i,
  input  logic [5:0]  column_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  data_pins_o,
  output logic        rs_pin_o,
  output logic        enable_pin_o,
  output logic        power_pin_o,
  output logic        busy_res_o,
  output logic        dropped_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);

  lcdni_pkg::cfg_t cfg_q;
  lcdni_pkg::req_t front_req;
  lcdni_pkg::req_t head_req;
  lcdni_pkg::res_t res;
  logic            push;
  logic            full;
  logic            head_valid;
  logic            pop;

  assign cfg_ready_o = 1'b1;

  // Timing registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_pulse <= lcdni_pkg::ENABLE_PULSE_RST;
      cfg_q.short_wait   <= lcdni_pkg::SHORT_WAIT_RST;
      cfg_q.clear_wait   <= lcdni_pkg::CLEAR_WAIT_RST;
      cfg_q.powerup_wait <= lcdni_pkg::POWERUP_WAIT_RST;
      cfg_q.reset_long   <= lcdni_pkg::RESET_LONG_RST;
      cfg_q.reset_short  <= lcdni_pkg::RESET_SHORT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lcdni_pkg::CFG_IDX_ENABLE_PULSE: cfg_q.enable_pulse <= cfg_data_i[7:0];
        lcdni_pkg::CFG_IDX_SHORT_WAIT:   cfg_q.short_wait   <= cfg_data_i[15:0];
        lcdni_pkg::CFG_IDX_CLEAR_WAIT:   cfg_q.clear_wait   <= cfg_data_i[15:0];
        lcdni_pkg::CFG_IDX_POWERUP_WAIT: cfg_q.powerup_wait <= cfg_data_i;
        lcdni_pkg::CFG_IDX_RESET_LONG:   cfg_q.reset_long   <= cfg_data_i[15:0];
        lcdni_pkg::CFG_IDX_RESET_SHORT:  cfg_q.reset_short  <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  lcdni_front #(
    .COLUMNS (COLUMNS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .data_byte_i  (data_byte_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .queue_full_i (full),
    .push_o       (push),
    .req_o        (front_req)
  );

  lcdni_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (front_req),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .pop_req_o  (head_req)
  );

  lcdni_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (head_valid),
    .req_i       (head_req),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign data_pins_o  = res.data_pins;
  assign rs_pin_o     = res.rs_pin;
  assign enable_pin_o = res.enable_pin;
  assign power_pin_o  = res.power_pin;
  assign busy_res_o   = res.busy_res;
  assign dropped_o    = res.dropped;

endmodule

>>> design/lcdni_checker.sv
module lcdni_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] data_pins_o,
  input logic       rs_pin_o,
  input logic       enable_pin_o,
  input logic       busy_res_o,
  input logic       dropped_o,
  input logic       cfg_ready_o
);

  // A stalled result holds its pins.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_pins_o) &&
    $stable(rs_pin_o) && $stable(enable_pin_o) && $stable(dropped_o))
    else $error("stalled result changed");

  // The enable strobe is only high inside a nibble transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && enable_pin_o |-> busy_res_o)
    else $error("enable high while idle");

  // A free output side drains the queue, so input stall clears next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || !out_stall_i |=> !in_stall_o)
    else $error("input stalled although output was free");

  // Configuration writes are never held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind char_lcd_nibble_interface_unit lcdni_checker u_lcdni_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .data_pins_o  (data_pins_o),
  .rs_pin_o     (rs_pin_o),
  .enable_pin_o (enable_pin_o),
  .busy_res_o   (busy_res_o),
  .dropped_o    (dropped_o),
  .cfg_ready_o  (cfg_ready_o)
);
